@@ hdl/q24_8_fixed_point_alu_assert.svh @@
// Assertion macros used by the Q24.8 ALU top level.
`ifndef Q24_8_FIXED_POINT_ALU_ASSERT_SVH
`define Q24_8_FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define Q24_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define Q24_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/q24_pkg.sv @@
// Types and operation codes of the Q24.8 fixed-point ALU.
package q24_pkg;

    typedef enum logic [3:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_LT       = 4'd4,
        FN_GT       = 4'd5,
        FN_LE       = 4'd6,
        FN_GE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_INC      = 4'd10,
        FN_DEC      = 4'd11,
        FN_MIN      = 4'd12,
        FN_MAX      = 4'd13,
        FN_FROM_INT = 4'd14,
        FN_TO_INT   = 4'd15
    } func_t;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               compare_true;
        logic               saturated;
        logic               divide_by_zero;
    } res_word_t;

    // Classified word as it waits in the queue for the back end.
    typedef struct packed {
        func_t              func;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        amag;
        logic [31:0]        den;
        logic               neg;
        logic               bzero;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

@@ hdl/q24_8_fixed_point_alu.sv @@
// Top level of the signed Q24.8 fixed-point ALU.
//
// Operation words enter on op (op_valid/op_stall) and each gives exactly one
// result word on res (res_valid/res_stall), in order. A word is taken at a
// rising edge with valid high and stall low.
// The front end classifies each word into a two-entry queue. The back end
// computes the product in its first stage and runs a restoring divider that
// retires one quotient bit per stage over FRAC_W+32 stages; every
// operation takes the same path, so results stay in order.
// A word passes the queue, the product stage, the divider stages and the
// result register; one word is taken every cycle while res is not stalled.
// The divider depth sets the latency; the multiplier sets the longest path.
// When res_valid and res_stall are both high the whole back end holds; the
// queue then fills and op_stall rises once it holds two words.
// Reset clears the queue and all valid bits; no words are lost afterward.
module q24_8_fixed_point_alu #(
    parameter int FRAC_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    output logic               op_stall,
    input  q24_pkg::in_word_t  op,
    output logic               res_valid,
    input  logic               res_stall,
    output q24_pkg::res_word_t res
);
    import q24_pkg::*;

    logic    head_valid;
    item_t   head;
    logic    take;
    q_stat_t qstat;

    q24_alu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op_stall   (op_stall),
        .op         (op),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .stat       (qstat)
    );

    q24_alu_back #(
        .FRAC_W (FRAC_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

`include "q24_8_fixed_point_alu_assert.svh"

    `Q24_ASSERT_IMP(a_dz_sat, res_valid && res.divide_by_zero, res.saturated, "divide by zero not saturated")
    `Q24_ASSERT_IMP(a_cmp_clean, res_valid && res.compare_true, res.result == 32'sd0 && !res.saturated, "compare word carries a value")
    `Q24_ASSERT_NXT(a_push_held, op_valid && !op_stall, !qstat.empty, "accepted word missing from queue")

endmodule

@@ hdl/q24_alu_front.sv @@
// Front end: accepts words, classifies them and queues them for the back end.
module q24_alu_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_stall,
    input  q24_pkg::in_word_t op,
    output logic             head_valid,
    output q24_pkg::item_t   head,
    input  logic             take,
    output q24_pkg::q_stat_t stat
);
    import q24_pkg::*;

    item_t       cls;
    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;

    always_comb
    begin
        cls.func  = op.func;
        cls.a     = op.operand_a;
        cls.b     = op.operand_b;
        cls.amag  = op.operand_a[31] ? 32'(~op.operand_a + 32'sd1) : 32'(op.operand_a);
        cls.den   = op.operand_b[31] ? 32'(~op.operand_b + 32'sd1) : 32'(op.operand_b);
        cls.neg   = op.operand_a[31] ^ op.operand_b[31];
        cls.bzero = (op.operand_b == 32'sd0);
    end

    assign op_stall   = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign push       = op_valid && !op_stall;
    assign pop        = take && head_valid;
    assign stat.empty = (cnt_reg == 2'd0);
    assign stat.full  = op_stall;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

@@ hdl/q24_alu_back.sv @@
// Back end: multiplier, bit-per-stage divider pipeline and result formatting.
module q24_alu_back #(
    parameter int FRAC_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  q24_pkg::item_t    head,
    output logic              take,
    output logic              res_valid,
    input  logic              res_stall,
    output q24_pkg::res_word_t res
);
    import q24_pkg::*;

    localparam int NW = 32 + FRAC_W;
    localparam logic signed [31:0] FI_HI = S32_MAX >>> FRAC_W;
    localparam logic signed [31:0] FI_LO = -(32'sd1 <<< (31 - FRAC_W));
    localparam logic [63:0] HALF = 64'd1 << (FRAC_W - 1);

    logic               ce;
    logic               v_reg  [NW + 1];
    item_t              it_reg [NW + 1];
    logic signed [63:0] p_reg  [NW + 1];
    logic [31:0]        r_reg  [NW + 1];
    logic [NW-1:0]      n_reg  [NW + 1];
    logic signed [63:0] prod;
    logic               res_valid_reg;
    res_word_t          res_reg;
    res_word_t          fin_next;

    // One quotient bit of the restoring division per stage.
    function automatic logic [32+NW-1:0] div_step(logic [31:0] r, logic [NW-1:0] n,
                                                  logic [31:0] d);
        logic [32:0] r_sh;
        logic        q_bit;
        r_sh  = {r, n[NW-1]};
        q_bit = (r_sh >= {1'b0, d});
        return {(q_bit ? 32'(r_sh - {1'b0, d}) : r_sh[31:0]), n[NW-2:0], q_bit};
    endfunction

    // The whole pipeline moves together whenever the output register can load.
    assign ce        = !res_valid_reg || !res_stall;
    assign take      = ce && head_valid;
    assign prod      = head.a * head.b;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NW; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            res_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= head_valid;
            for (int i = 1; i <= NW; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            res_valid_reg <= v_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            it_reg[0] <= head;
            p_reg[0]  <= prod;
            r_reg[0]  <= '0;
            n_reg[0]  <= {head.amag, {FRAC_W{1'b0}}};
            for (int k = 1; k <= NW; k++)
            begin
                it_reg[k]            <= it_reg[k-1];
                p_reg[k]             <= p_reg[k-1];
                {r_reg[k], n_reg[k]} <= div_step(r_reg[k-1], n_reg[k-1], it_reg[k-1].den);
            end
            res_reg <= fin_next;
        end
    end

    item_t              fi;
    logic signed [32:0] addend;
    logic signed [32:0] sum33;
    logic [63:0]        pmag;
    logic [63:0]        mq;
    logic               mneg;
    logic               rnd;
    logic [NW:0]        dq;

    always_comb
    begin
        fi     = it_reg[NW];
        addend = {fi.b[31], fi.b};
        fin_next = '0;
        unique case (fi.func)
            FN_SUB:  addend = -{fi.b[31], fi.b};
            FN_INC:  addend = 33'sd1;
            FN_DEC:  addend = -33'sd1;
            default: addend = {fi.b[31], fi.b};
        endcase
        sum33 = {fi.a[31], fi.a} + addend;

        mneg = p_reg[NW][63];
        pmag = mneg ? 64'(-p_reg[NW]) : 64'(p_reg[NW]);
        mq   = (pmag + HALF) >> FRAC_W;

        rnd  = ({r_reg[NW], 1'b0} >= {1'b0, fi.den});
        dq   = {1'b0, n_reg[NW]} + (NW+1)'(rnd);

        unique case (fi.func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC:
            begin
                if (sum33[32] != sum33[31])
                begin
                    fin_next.saturated = 1'b1;
                    fin_next.result    = sum33[32] ? S32_MIN : S32_MAX;
                end
                else
                begin
                    fin_next.result = sum33[31:0];
                end
            end
            FN_MUL:
            begin
                if (mneg ? (mq > 64'h8000_0000) : (mq > 64'h7FFF_FFFF))
                begin
                    fin_next.saturated = 1'b1;
                    fin_next.result    = mneg ? S32_MIN : S32_MAX;
                end
                else
                begin
                    fin_next.result = mneg ? -$signed(mq[31:0]) : $signed(mq[31:0]);
                end
            end
            FN_DIV:
            begin
                if (fi.bzero)
                begin
                    fin_next.divide_by_zero = 1'b1;
                    fin_next.saturated      = 1'b1;
                    fin_next.result         = fi.a[31] ? S32_MIN : S32_MAX;
                end
                else if (fi.neg ? (dq > (NW+1)'(33'h0_8000_0000))
                                : (dq > (NW+1)'(33'h0_7FFF_FFFF)))
                begin
                    fin_next.saturated = 1'b1;
                    fin_next.result    = fi.neg ? S32_MIN : S32_MAX;
                end
                else
                begin
                    fin_next.result = fi.neg ? -$signed(dq[31:0]) : $signed(dq[31:0]);
                end
            end
            FN_LT: fin_next.compare_true = (fi.a <  fi.b);
            FN_GT: fin_next.compare_true = (fi.a >  fi.b);
            FN_LE: fin_next.compare_true = (fi.a <= fi.b);
            FN_GE: fin_next.compare_true = (fi.a >= fi.b);
            FN_EQ: fin_next.compare_true = (fi.a == fi.b);
            FN_NE: fin_next.compare_true = (fi.a != fi.b);
            FN_MIN: fin_next.result = (fi.a < fi.b) ? fi.a : fi.b;
            FN_MAX: fin_next.result = (fi.a > fi.b) ? fi.a : fi.b;
            FN_FROM_INT:
            begin
                if (fi.a > FI_HI)
                begin
                    fin_next.saturated = 1'b1;
                    fin_next.result    = FI_HI <<< FRAC_W;
                end
                else if (fi.a < FI_LO)
                begin
                    fin_next.saturated = 1'b1;
                    fin_next.result    = S32_MIN;
                end
                else
                begin
                    fin_next.result = fi.a <<< FRAC_W;
                end
            end
            FN_TO_INT: fin_next.result = fi.a >>> FRAC_W;
        endcase
    end

endmodule
